// ===== rtl/core/mandelbrot_escape_time_pixel_macros.svh =====
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// same-cycle implication, held off during reset
`define MBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mbe_pkg.sv =====
package mbe_pkg;

  localparam int CFG_W     = 48;
  localparam int STEP_W    = 47;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN,
    REG_Y_MAX,
    REG_STEP_X,
    REG_STEP_Y,
    REG_MAX_ITER
  } cfg_reg_t;

  localparam int                   MAX_ITER_RESET = 256;
  localparam logic [15:0]          MAX_ITER_MASK  = 16'hFFFF;

  // offset along an axis is clamped to 2^49 before it is added to the edge
  localparam int                   CLAMP_W     = 50;
  localparam logic [CLAMP_W-1:0]   COORD_CLAMP = 50'h2_0000_0000_0000;

endpackage

// ===== rtl/core/mbe_mul.sv =====
module mbe_mul #(
  parameter int WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic               done,
  output logic [2*WIDTH-1:0] p
);

  localparam int NCH  = (WIDTH + 31) / 32;
  localparam int CH   = (WIDTH + NCH - 1) / NCH;
  localparam int PADW = NCH * CH;
  localparam int IW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int SW   = $clog2(2 * NCH);
  localparam int ACCW = 2 * PADW;
  localparam logic [IW-1:0] LAST = IW'(NCH - 1);

  logic [PADW-1:0] a_r, b_r;
  logic [IW-1:0]   ia, ib;
  logic            issuing;
  logic [2*CH-1:0] prod;
  logic [SW-1:0]   prod_sh;
  logic            prod_vld, prod_last;
  logic [ACCW-1:0] acc;

  // one chunk product a cycle, registered, then shifted into the accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      prod_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= 1'b0;
      prod_vld <= 1'b0;
      if (go) begin
        a_r     <= PADW'(a);
        b_r     <= PADW'(b);
        ia      <= '0;
        ib      <= '0;
        issuing <= 1'b1;
        acc     <= '0;
      end else if (issuing) begin
        prod      <= a_r[ia*CH +: CH] * b_r[ib*CH +: CH];
        prod_sh   <= SW'(ia) + SW'(ib);
        prod_last <= (ia == LAST) && (ib == LAST);
        prod_vld  <= 1'b1;
        if (ib == LAST) begin
          ib <= '0;
          ia <= ia + 1'b1;
        end else begin
          ib <= ib + 1'b1;
        end
        if ((ia == LAST) && (ib == LAST)) begin
          issuing <= 1'b0;
        end
      end
      if (prod_vld) begin
        acc <= acc + (ACCW'(prod) << (prod_sh * CH));
        if (prod_last) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign p = acc[2*WIDTH-1:0];

endmodule

// ===== rtl/core/mandelbrot_escape_time_pixel.sv =====
// Escape-time evaluator for one pixel. An item (column, row) is taken when start is high
// and busy is low; the block then maps it onto the window set by the configuration
// registers and iterates z = z^2 + c on a single shared multiplier that works on chunks
// of at most 32 bits, with NCH = ceil(MW/32) chunks per operand (MW = 48 at the default
// FRAC_BITS, so NCH = 2). Mapping takes one multiply pass per axis, and each iteration
// needs three passes (u*v, u*u and v*v). Busy stays high from the accept until the
// result strobe done, so a new item is not taken while the last one is being worked on.
// The result is valid on the output ports only while done is high and cannot be held
// off; a new item may be started in that same cycle. Configuration must be written only
// while busy is low; the block itself does not enforce this.
module mandelbrot_escape_time_pixel #(
  parameter int FRAC_BITS  = 44,
  parameter int ITER_BITS  = 16,
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbe_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         column,
  input  logic [COORD_BITS-1:0]         row,
  output logic                          done,
  output logic [COORD_BITS-1:0]         pixel_column,
  output logic [COORD_BITS-1:0]         pixel_row,
  output logic [ITER_BITS-1:0]          colour
);

  import mbe_pkg::*;

  // signed width of u and v, magnitude width, product width
  localparam int UW = ((FRAC_BITS + 2 > CFG_W - 1) ? FRAC_BITS + 2 : CFG_W - 1) + 2;
  localparam int MW = UW - 1;
  localparam int PW = 2 * MW;
  localparam int SUMW = CFG_W + 4;
  localparam logic [PW:0] FOUR = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CX,
    S_CY,
    S_TEST,
    S_UV,
    S_NV,
    S_SQU,
    S_SQV
  } state_t;

  function automatic logic signed [CFG_W-1:0] sat_coord(input logic signed [SUMW-1:0] s);
    logic [SUMW-CFG_W:0] top;
    top = s[SUMW-1:CFG_W-1];
    if ((top == '0) || (top == '1)) begin
      return s[CFG_W-1:0];
    end else if (s[SUMW-1]) begin
      return {1'b1, {(CFG_W-1){1'b0}}};
    end else begin
      return {1'b0, {(CFG_W-1){1'b1}}};
    end
  endfunction

  logic signed [CFG_W-1:0]  x_min, y_max;
  logic [STEP_W-1:0]        step_x, step_y;
  logic [ITER_BITS-1:0]     max_iter;

  state_t                   state;
  logic [COORD_BITS-1:0]    col_r, row_r;
  logic signed [UW-1:0]     cx, cy, u, v;
  logic [PW-1:0]            u2, v2;
  logic signed [PW:0]       d_r, uv_s;
  logic [ITER_BITS-1:0]     k;
  logic                     mul_go, mul_done;
  logic [MW-1:0]            mul_a, mul_b;
  logic [PW-1:0]            mul_p;

  logic [CLAMP_W-1:0]       pc;
  logic signed [SUMW-1:0]   off, sum_x, sum_y;
  logic [PW:0]              mag2;
  logic                     escaped;
  logic [MW-1:0]            mag_u, mag_v;
  logic signed [UW-1:0]     nu, nv;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min    <= '0;
      y_max    <= '0;
      step_x   <= '0;
      step_y   <= '0;
      max_iter <= ITER_BITS'(MAX_ITER_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_X_MIN:    x_min    <= cfg_data;
        REG_Y_MAX:    y_max    <= cfg_data;
        REG_STEP_X:   step_x   <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:   step_y   <= cfg_data[STEP_W-1:0];
        REG_MAX_ITER: max_iter <= cfg_data[ITER_BITS-1:0] & ITER_BITS'(MAX_ITER_MASK);
        default: ;
      endcase
    end
  end

  mbe_mul #(.WIDTH(MW)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mul_p)
  );

  always_comb begin
    pc      = (mul_p > PW'(COORD_CLAMP)) ? COORD_CLAMP : mul_p[CLAMP_W-1:0];
    off     = $signed({{(SUMW-CLAMP_W){1'b0}}, pc});
    sum_x   = SUMW'(x_min) + off;
    sum_y   = SUMW'(y_max) - off;
    mag2    = {1'b0, u2} + {1'b0, v2};
    escaped = (mag2 >= FOUR);
    mag_u   = u[UW-1] ? MW'(-u) : MW'(u);
    mag_v   = v[UW-1] ? MW'(-v) : MW'(v);
    // floor division by a power of two is an arithmetic right shift
    nu      = UW'(d_r >>> FRAC_BITS) + cx;
    nv      = UW'(uv_s >>> (FRAC_BITS - 1)) + cy;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      mul_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      mul_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            col_r  <= column;
            row_r  <= row;
            mul_a  <= MW'(step_x);
            mul_b  <= MW'(column);
            mul_go <= 1'b1;
            state  <= S_CX;
          end
        end
        S_CX: begin
          if (mul_done) begin
            cx     <= UW'(sat_coord(sum_x));
            mul_a  <= MW'(step_y);
            mul_b  <= MW'(row_r);
            mul_go <= 1'b1;
            state  <= S_CY;
          end
        end
        S_CY: begin
          if (mul_done) begin
            cy    <= UW'(sat_coord(sum_y));
            u     <= '0;
            v     <= '0;
            u2    <= '0;
            v2    <= '0;
            k     <= ITER_BITS'(1);
            state <= S_TEST;
          end
        end
        S_TEST: begin
          d_r <= $signed({1'b0, u2}) - $signed({1'b0, v2});
          if ((k >= max_iter) || escaped) begin
            pixel_column <= col_r;
            pixel_row    <= row_r;
            colour       <= (k >= max_iter) ? '0 : (k & ITER_BITS'(MAX_ITER_MASK));
            done         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            mul_a  <= mag_u;
            mul_b  <= mag_v;
            mul_go <= 1'b1;
            state  <= S_UV;
          end
        end
        S_UV: begin
          if (mul_done) begin
            // sign of u*v from the old u and v
            uv_s  <= (u[UW-1] ^ v[UW-1]) ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
            u     <= nu;
            state <= S_NV;
          end
        end
        S_NV: begin
          v      <= nv;
          mul_a  <= mag_u;
          mul_b  <= mag_u;
          mul_go <= 1'b1;
          state  <= S_SQU;
        end
        S_SQU: begin
          if (mul_done) begin
            u2     <= mul_p;
            mul_a  <= mag_v;
            mul_b  <= mag_v;
            mul_go <= 1'b1;
            state  <= S_SQV;
          end
        end
        S_SQV: begin
          if (mul_done) begin
            v2    <= mul_p;
            k     <= k + 1'b1;
            state <= S_TEST;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/mbe_checker.sv =====
`include "mandelbrot_escape_time_pixel_macros.svh"

module mbe_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // the result word is shown as the block drops back to idle
  `MBE_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")

  `MBE_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")

  // no result can appear the cycle after an item is taken
  `MBE_ASSERT_NEXT(a_no_instant, start && !busy, !done, "result right after accept")

  `MBE_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

endmodule

bind mandelbrot_escape_time_pixel mbe_checker u_mbe_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ===== sim/mandelbrot_escape_time_pixel_checker.sv =====
module mandelbrot_escape_time_pixel_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbe_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          start,
  input  logic                          busy,
  input  logic [11:0]                   column,
  input  logic [11:0]                   row,
  input  logic                          done,
  input  logic [11:0]                   pixel_column,
  input  logic [11:0]                   pixel_row,
  input  logic [15:0]                   colour,
  output int                            pending,
  output int                            mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbe_pkg::*;

  localparam int FRAC = 44;
  localparam logic signed [127:0] Q_MAX = (128'sd1 <<< (CFG_W - 1)) - 1;
  localparam logic signed [127:0] Q_MIN = -(128'sd1 <<< (CFG_W - 1));
  // |z|^2 >= 4 at double fraction width
  localparam logic signed [127:0] BAILOUT = 128'sd4 <<< (2 * FRAC);

  typedef struct packed {
    logic [11:0] px_column;
    logic [11:0] px_row;
    logic [15:0] px_colour;
  } pixel_word_t;

  logic signed [CFG_W-1:0] win_x_min;
  logic signed [CFG_W-1:0] win_y_max;
  logic [STEP_W-1:0]       win_step_x;
  logic [STEP_W-1:0]       win_step_y;
  logic [15:0]             iter_limit;
  pixel_word_t             expected_pixels[$];
  int                      mismatch_total;

  // one axis of c: origin +/- idx*pitch, offset clamped, then saturated to 48 bits
  function automatic logic signed [127:0] map_axis(input logic signed [CFG_W-1:0] origin,
                                                   input logic [11:0] idx,
                                                   input logic [STEP_W-1:0] pitch,
                                                   input bit downward);
    logic signed [127:0] offset;
    logic signed [127:0] pos;
    offset = 128'(idx) * 128'(pitch);
    if (offset > 128'(COORD_CLAMP)) offset = 128'(COORD_CLAMP);
    pos = downward ? origin - offset : origin + offset;
    if (pos > Q_MAX) pos = Q_MAX;
    if (pos < Q_MIN) pos = Q_MIN;
    return pos;
  endfunction

  function automatic logic [15:0] escape_count(input logic [11:0] col, input logic [11:0] rw);
    logic signed [127:0] c_re, c_im, u, v, u_sq, v_sq, two_uv;
    int unsigned k;
    c_re = map_axis(win_x_min, col, win_step_x, 1'b0);
    c_im = map_axis(win_y_max, rw, win_step_y, 1'b1);
    u = '0;
    v = '0;
    u_sq = '0;
    v_sq = '0;
    k = 1;
    while (k < iter_limit && u_sq + v_sq < BAILOUT) begin
      two_uv = (u * v) <<< 1;
      // arithmetic shifts floor towards minus infinity
      v = (two_uv >>> FRAC) + c_im;
      u = ((u_sq - v_sq) >>> FRAC) + c_re;
      u_sq = u * u;
      v_sq = v * v;
      k++;
    end
    return (k >= iter_limit) ? 16'd0 : 16'(k);
  endfunction

  always @(posedge clk) begin
    pixel_word_t want;
    if (rst) begin
      win_x_min = '0;
      win_y_max = '0;
      win_step_x = '0;
      win_step_y = '0;
      iter_limit = 16'(MAX_ITER_RESET);
      mismatch_total = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_X_MIN:    win_x_min = cfg_data;
          REG_Y_MAX:    win_y_max = cfg_data;
          REG_STEP_X:   win_step_x = cfg_data[STEP_W-1:0];
          REG_STEP_Y:   win_step_y = cfg_data[STEP_W-1:0];
          REG_MAX_ITER: iter_limit = cfg_data[15:0] & MAX_ITER_MASK;
          default: ;
        endcase
      end
      if (start && !busy)
        expected_pixels.push_back('{column, row, escape_count(column, row)});
      if (done) begin
        if (expected_pixels.size() == 0) begin
          if (mismatch_total < 10)
            $display("%0t: unexpected word col %0d row %0d colour %0d", $realtime,
                     pixel_column, pixel_row, colour);
          mismatch_total++;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_column !== want.px_column || pixel_row !== want.px_row ||
              colour !== want.px_colour) begin
            if (mismatch_total < 10)
              $display("%0t: expected col %0d row %0d colour %0d, got col %0d row %0d colour %0d",
                       $realtime, want.px_column, want.px_row, want.px_colour,
                       pixel_column, pixel_row, colour);
            mismatch_total++;
          end
        end
      end
    end
    pending <= expected_pixels.size();
    mismatches <= mismatch_total;
  end

endmodule

// ===== sim/mandelbrot_escape_time_pixel_test.sv =====
module mandelbrot_escape_time_pixel_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mbe_pkg::*;

  localparam int STALL_LIMIT = 40000;
  localparam int SPARE_REG_LO = int'(REG_MAX_ITER) + 1;
  localparam logic [CFG_W-1:0] Q_NEG_LIMIT = 48'h8000_0000_0000;
  localparam logic [CFG_W-1:0] Q_POS_LIMIT = 48'h7FFF_FFFF_FFFF;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 start;
  logic                 busy;
  logic [11:0]          column;
  logic [11:0]          row;
  logic                 done;
  logic [11:0]          pixel_column;
  logic [11:0]          pixel_row;
  logic [15:0]          colour;
  int                   pending;
  int                   mismatches;
  int                   quiet_cycles;

  mandelbrot_escape_time_pixel DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy), .column(column), .row(row),
    .done(done), .pixel_column(pixel_column), .pixel_row(pixel_row), .colour(colour)
  );

  mandelbrot_escape_time_pixel_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy), .column(column), .row(row),
    .done(done), .pixel_column(pixel_column), .pixel_row(pixel_row), .colour(colour),
    .pending(pending), .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog on cycles where no word moves either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [CFG_W-1:0] any48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [11:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic settle();
    do @(posedge clk); while (busy || pending != 0);
  endtask

  task automatic issue_pixel(input logic [11:0] c, input logic [11:0] r);
    start <= 1'b1;
    column <= c;
    row <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic load_window(input logic [CFG_W-1:0] x0, y0, sx, sy, iter, input bit spare);
    start <= 1'b0;
    settle();
    // writes to unused indexes must change nothing
    if (spare)
      write_reg(CFG_IDX_W'($urandom_range(SPARE_REG_LO, 2 ** CFG_IDX_W - 1)), any48());
    write_reg(REG_X_MIN, x0);
    write_reg(REG_Y_MAX, y0);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    write_reg(REG_MAX_ITER, iter);
    cfg_write <= 1'b0;
  endtask

  task automatic run_pixels(input int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        issue_pixel(pick_coord(), pick_coord());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        start <= 1'b0;
        if ($urandom_range(0, 15) == 0) settle();
        else repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic random_phase(input int count, input int iter_lo, input int iter_hi);
    logic [CFG_W-1:0] x0, y0, sx, sy;
    int mode;
    mode = $urandom_range(0, 3);
    if (mode == 3) begin
      x0 = any48();
      y0 = any48();
      sx = any48();
      sy = any48();
    end else begin
      // window around the set, zoomed in by mode
      x0 = 48'(-(longint'($urandom_range(16, 40)) <<< 40) + longint'($urandom));
      y0 = 48'((longint'($urandom_range(8, 24)) <<< 40) + longint'($urandom));
      sx = 48'(((longint'($urandom_range(0, 3)) << 32) | longint'($urandom)) >> (mode * 5));
      sy = 48'(((longint'($urandom_range(0, 3)) << 32) | longint'($urandom)) >> (mode * 5));
    end
    load_window(x0, y0, sx, sy, {32'($urandom), 16'($urandom_range(iter_lo, iter_hi))},
                $urandom_range(0, 1) == 1);
    run_pixels(count);
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_X_MIN;
    cfg_data <= '0;
    start <= 1'b0;
    column <= '0;
    row <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset window: c is zero everywhere, so interior
    issue_pixel('0, '0);
    issue_pixel('1, '1);

    // classic window; step_x and max_iter carry junk in masked bits
    load_window(48'hE000_0000_0000, 48'h1400_0000_0000, 48'h8003_0000_0000,
                48'h0002_8000_0000, 48'hFFFF_FFFF_0040, 1'b0);
    issue_pixel('0, '0);
    issue_pixel('1, '1);
    issue_pixel(12'd2730, 12'd2048);
    issue_pixel(12'hAAA, 12'h555);
    issue_pixel(12'h555, 12'hAAA);
    issue_pixel(12'd2048, 12'd1024);

    // extreme edges and steps; zero, one and two iteration limits
    for (int lim = 0; lim <= 2; lim++) begin
      load_window(Q_NEG_LIMIT, Q_POS_LIMIT, Q_POS_LIMIT, Q_POS_LIMIT, 48'(lim), lim != 0);
      issue_pixel('0, '0);
      issue_pixel('1, '1);
    end
    issue_pixel(12'd1, 12'd1);

    // origin at zero, huge steps saturate both ways
    load_window('0, '0, Q_POS_LIMIT, Q_POS_LIMIT, 48'd3, 1'b1);
    issue_pixel('0, '0);
    issue_pixel('1, '0);
    issue_pixel('0, '1);
    issue_pixel(12'd1, '0);

    // largest limit, but every point lies at or right of 3.0 and escapes at once
    load_window(48'h3000_0000_0000, '0, 48'($urandom), 48'($urandom),
                {32'($urandom), 16'hFFFF}, 1'b1);
    run_pixels(6);

    for (int p = 0; p < 7; p++) begin
      random_phase(105, 1, 32);
      if (p == 3) random_phase(20, 100, 300);
    end

    start <= 1'b0;
    settle();
    repeat (64) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
